// ===== rtl/glmf_pkg.sv =====
// ----------------------------------------------------------------------------
// glmf_pkg - shared constants and types of the grid local maximum finder
// Default sizes, configuration register map and result slot positions.
// ----------------------------------------------------------------------------
package glmf_pkg;

  localparam int MAX_COLS_DEF     = 64;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration channel layout
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_ROWS_W  = 11;
  localparam int NUM_COLS_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_ROWS = 4'd0,
    REG_NUM_COLS = 4'd1
  } cfg_reg_t;

  // Result slots of one pixel, in raster order of the peaks
  localparam int SLOT_ABOVE = 0;  // pixel one row up, same column
  localparam int SLOT_LEFT  = 1;  // last row, pixel to the left
  localparam int SLOT_HERE  = 2;  // last pixel of the frame itself
  localparam int NUM_SLOTS  = 3;

endpackage

// ===== rtl/glmf_channels.sv =====
// ----------------------------------------------------------------------------
// glmf_channels - valid/ready channel interfaces
// Pixel input, peak result and configuration write channels.
// ----------------------------------------------------------------------------
interface glmf_pixel_if #(
  parameter int SAMPLE_WIDTH = glmf_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface glmf_peak_if #(
  parameter int ROW_W = 10,
  parameter int COL_W = 6
);
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] peak_row;
  logic [COL_W-1:0] peak_col;
  logic             last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                  output ready);
endinterface

interface glmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [glmf_pkg::CFG_INDEX_W-1:0] index;
  logic [glmf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/glmf_cfg.sv =====
// ----------------------------------------------------------------------------
// glmf_cfg - frame size registers
// Clamp row and column counts on write and keep the last valid index.
// ----------------------------------------------------------------------------
module glmf_cfg #(
  parameter int MAX_ROWS = glmf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = glmf_pkg::MAX_COLS_DEF,
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int COL_W = $clog2(MAX_COLS)
) (
  input  logic             clk,
  input  logic             rst,
  glmf_cfg_if.sink         cfg,
  output logic [ROW_W-1:0] row_last,
  output logic [COL_W-1:0] col_last,
  output logic             restart
);

  logic [glmf_pkg::NUM_ROWS_W-1:0] rows_val;
  logic [glmf_pkg::NUM_COLS_W-1:0] cols_val;
  logic [ROW_W-1:0]                row_last_next;
  logic [COL_W-1:0]                col_last_next;

  assign cfg.ready = !rst;
  assign rows_val  = cfg.data[glmf_pkg::NUM_ROWS_W-1:0];
  assign cols_val  = cfg.data[glmf_pkg::NUM_COLS_W-1:0];

  // Restart the frame at the same edge that writes a known register
  assign restart = cfg.valid && cfg.ready
                   && (cfg.index == glmf_pkg::REG_NUM_ROWS
                       || cfg.index == glmf_pkg::REG_NUM_COLS);

  // Zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (rows_val == '0) begin
      row_last_next = '0;
    end else if (32'(rows_val) > 32'(MAX_ROWS)) begin
      row_last_next = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last_next = ROW_W'(rows_val - 1'b1);
    end
    if (cols_val == '0) begin
      col_last_next = '0;
    end else if (32'(cols_val) > 32'(MAX_COLS)) begin
      col_last_next = COL_W'(MAX_COLS - 1);
    end else begin
      col_last_next = COL_W'(cols_val - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= '0;
      col_last <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          glmf_pkg::REG_NUM_ROWS: begin
            row_last <= row_last_next;
          end
          glmf_pkg::REG_NUM_COLS: begin
            col_last <= col_last_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/glmf_line_mem.sv =====
// ----------------------------------------------------------------------------
// glmf_line_mem - line buffer memory
// One write port, two registered read ports, write-first on address match.
// ----------------------------------------------------------------------------
module glmf_line_mem #(
  parameter int DEPTH = glmf_pkg::MAX_COLS_DEF,
  parameter int WIDTH = 2 * glmf_pkg::SAMPLE_WIDTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward the word being written so a read in the same cycle sees it
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
      rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end
  end

endmodule

// ===== rtl/glmf_decide.sv =====
// ----------------------------------------------------------------------------
// glmf_decide - peak decision for one pixel
// Compare the pending centers against their neighbors and flag result slots.
// ----------------------------------------------------------------------------
module glmf_decide #(
  parameter int SAMPLE_WIDTH = glmf_pkg::SAMPLE_WIDTH_DEF,
  parameter int ROW_W        = 10,
  parameter int COL_W        = 6
) (
  input  logic signed [SAMPLE_WIDTH-1:0]  px,
  input  logic        [ROW_W-1:0]         row,
  input  logic        [COL_W-1:0]         col,
  input  logic        [ROW_W-1:0]         row_last,
  input  logic        [COL_W-1:0]         col_last,
  input  logic signed [SAMPLE_WIDTH-1:0]  above,       // previous row, this column
  input  logic signed [SAMPLE_WIDTH-1:0]  above2,      // two rows up, this column
  input  logic signed [SAMPLE_WIDTH-1:0]  above_left,  // previous row, left column
  input  logic signed [SAMPLE_WIDTH-1:0]  above_right, // previous row, right column
  input  logic signed [SAMPLE_WIDTH-1:0]  left1,
  input  logic signed [SAMPLE_WIDTH-1:0]  left2,
  output logic        [glmf_pkg::NUM_SLOTS-1:0] hit
);

  logic has_up1;
  logic has_up2;
  logic has_left1;
  logic has_left2;
  logic is_last_row;
  logic is_last_col;

  assign has_up1     = (row != '0);
  assign has_up2     = (row > ROW_W'(1));
  assign has_left1   = (col != '0);
  assign has_left2   = (col > COL_W'(1));
  assign is_last_row = (row == row_last);
  assign is_last_col = (col == col_last);

  always_comb begin
    // Pixel above: its lower neighbor just arrived
    hit[glmf_pkg::SLOT_ABOVE] = has_up1 && (above >= px)
                                && !(has_up2 && above < above2)
                                && !(has_left1 && above < above_left)
                                && !(!is_last_col && above < above_right);
    // Last row: pixel to the left, its right neighbor just arrived
    hit[glmf_pkg::SLOT_LEFT]  = is_last_row && has_left1 && (left1 >= px)
                                && !(has_left2 && left1 < left2)
                                && !(has_up1 && left1 < above_left);
    // Last pixel of the frame
    hit[glmf_pkg::SLOT_HERE]  = is_last_row && is_last_col
                                && !(has_left1 && px < left1)
                                && !(has_up1 && px < above);
  end

endmodule

// ===== rtl/glmf_out.sv =====
// ----------------------------------------------------------------------------
// glmf_out - result buffer
// Hold the flagged slots of one pixel and hand them out one per transaction.
// ----------------------------------------------------------------------------
module glmf_out #(
  parameter int ROW_W = 10,
  parameter int COL_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [glmf_pkg::NUM_SLOTS-1:0] load_hit,
  input  logic [ROW_W-1:0]               load_row,
  input  logic [COL_W-1:0]               load_col,
  output logic                           free,
  glmf_peak_if.source                    peaks
);

  logic [glmf_pkg::NUM_SLOTS-1:0] pend;
  logic [glmf_pkg::NUM_SLOTS-1:0] pend_rest;
  logic [ROW_W-1:0]               row;
  logic [COL_W-1:0]               col;
  logic                           single;
  logic                           take;

  assign pend_rest = pend & (pend - 1'b1);  // drop the lowest pending slot
  assign single    = (pend != '0) && (pend_rest == '0);
  assign take      = peaks.valid && peaks.ready;
  assign free      = (pend == '0) || (single && peaks.ready);

  assign peaks.valid       = (pend != '0);
  assign peaks.last_of_run = single;

  always_comb begin
    priority if (pend[glmf_pkg::SLOT_ABOVE]) begin
      peaks.peak_row = row - 1'b1;
      peaks.peak_col = col;
    end else if (pend[glmf_pkg::SLOT_LEFT]) begin
      peaks.peak_row = row;
      peaks.peak_col = col - 1'b1;
    end else begin
      peaks.peak_row = row;
      peaks.peak_col = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= load_hit;
    end else if (take) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row <= load_row;
      col <= load_col;
    end
  end

endmodule

// ===== rtl/grid_local_maximum_finder_top.sv =====
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_top - 4-neighbor local maximum finder
// Streams a raster frame and reports pixels not below any existing neighbor.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                              transaction
//   -------  ---  -----------------------------------  -------------------------
//   pixels   in   pixel_value (signed sample)          one sample, raster order
//   peaks    out  peak_row, peak_col, last_of_run      one detected peak
//   cfg      in   index, data                          one register write
//
// One pixel is accepted every cycle unless the pixel side stalls. A pixel waits in
// the input register, where the line buffer words for its column arrive from the
// registered memory ports, and its up to three peaks land in the result buffer as
// it leaves. Peaks leave one per cycle while peaks is ready; the pixel side stalls
// only while the input register is full and the result buffer holds more than one
// pending peak, or one while peaks is stalled. Reset clears the counters and
// buffers' control state and holds both input channels off; the line buffer needs
// no clearing pass, since only entries written earlier in the frame are read.
// A known register write restarts the frame at row 0, column 0 from the next pixel.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder_top #(
  parameter int MAX_COLS     = glmf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = glmf_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_WIDTH = glmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  glmf_pixel_if.sink  pixels,
  glmf_peak_if.source peaks,
  glmf_cfg_if.sink    cfg
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);

  // Frame size
  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] col_last;
  logic             restart;

  // Scan position of the next pixel to accept
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [COL_W-1:0] right_addr;
  logic             accept;

  // Input register
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_px;
  logic [ROW_W-1:0]               s1_row;
  logic [COL_W-1:0]               s1_col;
  logic                           s1_adv;

  // Line buffer: each word holds {two rows up, previous row} for one column
  logic [2*SAMPLE_WIDTH-1:0] lb_here;
  logic [2*SAMPLE_WIDTH-1:0] lb_right;
  logic signed [SAMPLE_WIDTH-1:0] above;
  logic signed [SAMPLE_WIDTH-1:0] above2;
  logic signed [SAMPLE_WIDTH-1:0] above_right;

  // Row context, updated as each pixel leaves the input register
  logic signed [SAMPLE_WIDTH-1:0] above_left;
  logic signed [SAMPLE_WIDTH-1:0] left1;
  logic signed [SAMPLE_WIDTH-1:0] left2;

  logic [glmf_pkg::NUM_SLOTS-1:0] hit;
  logic                           out_free;

  glmf_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .row_last (row_last),
    .col_last (col_last),
    .restart  (restart)
  );

  // Take a pixel whenever the input register is empty or drains this cycle
  assign s1_adv       = s1_valid && out_free;
  assign pixels.ready = !rst && (!s1_valid || out_free);
  assign accept       = pixels.valid && pixels.ready;

  // Right neighbor column; unused on the last column, so hold it in range
  assign right_addr = (col_count == col_last) ? '0 : col_count + 1'b1;

  // Advance the scan position; wrap to the frame start after the last pixel
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_count == col_last) begin
        col_count <= '0;
        row_count <= (row_count == row_last) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px  <= pixels.pixel_value;
      s1_row <= row_count;
      s1_col <= col_count;
    end
  end

  // Read at acceptance so the words line up with the input register; the
  // pixel leaving at the same edge writes its column first when they collide
  glmf_line_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * SAMPLE_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .re      (accept),
    .raddr_a (col_count),
    .raddr_b (right_addr),
    .we      (s1_adv),
    .waddr   (s1_col),
    .wdata   ({above, s1_px}),
    .rdata_a (lb_here),
    .rdata_b (lb_right)
  );

  assign above       = lb_here[SAMPLE_WIDTH-1:0];
  assign above2      = lb_here[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign above_right = lb_right[SAMPLE_WIDTH-1:0];

  // Shift the row context; the previous center becomes the left sample and its upper sample the upper-left one
  always_ff @(posedge clk) begin
    if (rst) begin
      left1      <= '0;
      left2      <= '0;
      above_left <= '0;
    end else if (s1_adv) begin
      left2      <= (s1_col == '0) ? '0 : left1;
      left1      <= s1_px;
      above_left <= above;
    end
  end

  glmf_decide #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ROW_W        (ROW_W),
    .COL_W        (COL_W)
  ) u_decide (
    .px          (s1_px),
    .row         (s1_row),
    .col         (s1_col),
    .row_last    (row_last),
    .col_last    (col_last),
    .above       (above),
    .above2      (above2),
    .above_left  (above_left),
    .above_right (above_right),
    .left1       (left1),
    .left2       (left2),
    .hit         (hit)
  );

  glmf_out #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_adv),
    .load_hit (hit),
    .load_row (s1_row),
    .load_col (s1_col),
    .free     (out_free),
    .peaks    (peaks)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the grid local maximum finder
// Streams raster frames of signed samples through the block and checks every
// reported peak, field by field and in order, against an in-bench predictor
// of the 4-neighbor peak rule. Register writes move the frame size through
// its limits, and random stalls on both channels exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SW             = glmf_pkg::SAMPLE_WIDTH_DEF;
  localparam int MAX_ROWS       = glmf_pkg::MAX_ROWS_DEF;
  localparam int MAX_COLS       = glmf_pkg::MAX_COLS_DEF;
  localparam int CFG_INDEX_W    = glmf_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W     = glmf_pkg::CFG_DATA_W;
  localparam int NUM_ROWS_W     = glmf_pkg::NUM_ROWS_W;
  localparam int NUM_COLS_W     = glmf_pkg::NUM_COLS_W;
  localparam int ROW_W          = 10;
  localparam int COL_W          = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;     // covers a pixel still in flight
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int TALL_ITEMS     = 40;
  localparam int RANDOM_ITEMS   = 210;
  localparam int CALM_ITEMS     = 60;    // tail of the run without idling

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } peak_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;

  glmf_pixel_if #(.SAMPLE_WIDTH(SW)) pix_bus ();
  glmf_peak_if #(.ROW_W(ROW_W), .COL_W(COL_W)) peak_bus ();
  glmf_cfg_if cfg_bus ();

  grid_local_maximum_finder_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_bus),
    .peaks  (peak_bus),
    .cfg    (cfg_bus)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: two line buffers, the two samples to the left in the
  // current row, the raster position of the next sample and the frame size.
  // --------------------------------------------------------------------------
  sample_t              line_up  [MAX_COLS];
  sample_t              line_up2 [MAX_COLS];
  sample_t              left1;
  sample_t              left2;
  int                   row_pos;
  int                   col_pos;
  logic [NUM_ROWS_W-1:0] frame_rows;
  logic [NUM_COLS_W-1:0] frame_cols;

  peak_t pending_peaks [$];
  int    mismatches = 0;
  bit    idle_on    = 1'b1;
  bit    hold_req   = 1'b0;
  int    quiet_cycles = 0;

  function automatic peak_t make_peak(input int r, input int c);
    peak_t p;
    p.row  = ROW_W'(r);
    p.col  = COL_W'(c);
    p.last = 1'b0;
    return p;
  endfunction

  // Work out the peaks that one accepted sample decides and advance the
  // raster position. Out-of-range sizes clip to 1 and to the maximum.
  function automatic void predict_peaks(input sample_t px);
    int      rows_eff;
    int      cols_eff;
    int      r;
    int      c;
    logic    keep;
    sample_t ctr;
    peak_t   found [$];

    rows_eff = (frame_rows == 0) ? 1 : ((frame_rows > MAX_ROWS) ? MAX_ROWS : frame_rows);
    cols_eff = (frame_cols == 0) ? 1 : ((frame_cols > MAX_COLS) ? MAX_COLS : frame_cols);
    r = row_pos;
    c = col_pos;
    if (r >= rows_eff) r = 0;
    if (c >= cols_eff) c = 0;

    // The pixel just above is complete once its lower neighbor arrives
    if (r >= 1) begin
      ctr  = line_up[c];
      keep = (ctr >= px);
      if (r >= 2 && ctr < line_up2[c]) keep = 1'b0;
      if (c >= 1 && ctr < line_up2[c-1]) keep = 1'b0;
      if (c + 1 < cols_eff && ctr < line_up[c+1]) keep = 1'b0;
      if (keep) found.push_back(make_peak(r - 1, c));
    end

    if (r == rows_eff - 1) begin
      // Bottom row: the left pixel is complete once its right neighbor arrives
      if (c >= 1) begin
        ctr  = left1;
        keep = (ctr >= px);
        if (c >= 2 && ctr < left2) keep = 1'b0;
        if (r >= 1 && ctr < line_up2[c-1]) keep = 1'b0;
        if (keep) found.push_back(make_peak(r, c - 1));
      end
      // The last pixel of the frame has no neighbor still to come
      if (c == cols_eff - 1) begin
        keep = 1'b1;
        if (c >= 1 && px < left1) keep = 1'b0;
        if (r >= 1 && px < line_up[c]) keep = 1'b0;
        if (keep) found.push_back(make_peak(r, c));
      end
    end

    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_peaks.push_back(found[i]);

    line_up2[c] = line_up[c];
    line_up[c]  = px;
    if (c == 0) begin
      left2 = '0;
      left1 = px;
    end else begin
      left2 = left1;
      left1 = px;
    end

    c++;
    if (c >= cols_eff) begin
      c = 0;
      r++;
      if (r >= rows_eff) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  // Full-range samples half the time, with small values to force ties and the
  // two extremes of the sample range.
  function automatic sample_t rand_pixel();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return sample_t'(int'($urandom_range(0, 4)) - 2);
      1: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Peak receiver: random stall bursts, plus a long hold-off on request.
  // Only one ready update per clock edge.
  // --------------------------------------------------------------------------
  initial begin : peak_ready_ctl
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    peak_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        peak_bus.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        peak_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(0, 15);
        peak_bus.ready <= 1'b0;
      end else begin
        peak_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare each peak transaction with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_peaks
    peak_t want;
    if (!rst && peak_bus.valid === 1'b1 && peak_bus.ready === 1'b1) begin
      if (pending_peaks.size() == 0) begin
        $error("unexpected peak: peak_row %0d peak_col %0d last_of_run %0b",
               peak_bus.peak_row, peak_bus.peak_col, peak_bus.last_of_run);
        mismatches++;
      end else begin
        want = pending_peaks.pop_front();
        if (peak_bus.peak_row !== want.row) begin
          $error("peak_row: expected %0d, actual %0d", want.row, peak_bus.peak_row);
          mismatches++;
        end
        if (peak_bus.peak_col !== want.col) begin
          $error("peak_col: expected %0d, actual %0d", want.col, peak_bus.peak_col);
          mismatches++;
        end
        if (peak_bus.last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, peak_bus.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which no channel completes a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
        (peak_bus.valid === 1'b1 && peak_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one sample, optionally after an idle burst; predict on acceptance.
  // Valid stays high afterwards so back-to-back samples need no toggle.
  task automatic send_pixel(input sample_t px);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= px;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    predict_peaks(px);
  endtask

  task automatic send_values(input sample_t vals [$]);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // Drop valid, wait for every expected peak, then let a pixel that
  // decided nothing drain out of the pipeline.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  value);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    case (idx)
      glmf_pkg::REG_NUM_ROWS: begin
        frame_rows = value[NUM_ROWS_W-1:0];
        row_pos    = 0;
        col_pos    = 0;
      end
      glmf_pkg::REG_NUM_COLS: begin
        frame_cols = value[NUM_COLS_W-1:0];
        row_pos    = 0;
        col_pos    = 0;
      end
      default: ;  // unknown index: nothing changes
    endcase
  endtask

  task automatic set_frame(input int rows, input int cols);
    write_reg(glmf_pkg::REG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(glmf_pkg::REG_NUM_COLS, CFG_DATA_W'(cols));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the frame is 1x1: every sample is a peak of its own.
  task automatic test_reset_frame();
    send_values('{SAMPLE_MAX, SAMPLE_MIN, sample_t'(0), sample_t'(-1)});
  endtask

  // 3x3 frames: one center peak among extremes, then all ties.
  task automatic test_extreme_values();
    set_frame(3, 3);
    send_values('{SAMPLE_MIN, sample_t'(0), SAMPLE_MIN,
                  sample_t'(0), SAMPLE_MAX, sample_t'(0),
                  SAMPLE_MIN, sample_t'(0), SAMPLE_MIN});
    send_values('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                  SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                  SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN});
  endtask

  // A single row and a single column: only existing neighbors count.
  task automatic test_single_line();
    set_frame(1, 5);
    send_values('{sample_t'(3), sample_t'(3), sample_t'(1), sample_t'(7), sample_t'(7)});
    set_frame(4, 1);
    send_values('{sample_t'(2), sample_t'(9), sample_t'(9), sample_t'(-4)});
  endtask

  // Register values outside the legal range clip to 1 or to the maximum.
  task automatic test_register_limits();
    set_frame(0, 0);
    send_random(2);
    // all data bits set: columns mask to 127 and clip to the maximum
    write_reg(glmf_pkg::REG_NUM_COLS, '1);
    send_random(MAX_COLS + 2);
    // bit 7 only: masks to zero columns, acts as one
    write_reg(glmf_pkg::REG_NUM_COLS, CFG_DATA_W'(128));
    send_random(2);
  endtask

  // Rows clipped to the maximum, one column: run down the first rows.
  task automatic test_tall_frame();
    write_reg(glmf_pkg::REG_NUM_ROWS, '1);
    write_reg(glmf_pkg::REG_NUM_COLS, CFG_DATA_W'(1));
    send_random(TALL_ITEMS);
  endtask

  // A known register write restarts the frame; unknown indexes do not.
  task automatic test_restart_and_unknown();
    set_frame(2, 3);
    send_random(4);
    write_reg(glmf_pkg::REG_NUM_COLS, CFG_DATA_W'(3));
    send_random(8);
    for (int i = glmf_pkg::REG_NUM_COLS + 1; i < (1 << CFG_INDEX_W); i++) begin
      write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom()));
    end
    send_random(4);
  endtask

  // Hold the peak side off while samples keep coming: every pixel of a
  // flat frame is a peak, so the result buffer fills and the input stalls.
  task automatic test_backpressure();
    set_frame(2, 8);
    hold_req = 1'b1;
    repeat (48) send_pixel(sample_t'(100));
    send_random(32);
  endtask

  // Random frame sizes, mostly small, some wide; whole frames, repeated
  // frames and the odd partial one. The tail runs without idling.
  task automatic test_random_frames();
    int sent;
    int rows;
    int cols;
    int count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        rows = $urandom_range(1, 3);
        cols = $urandom_range(33, MAX_COLS);
        count = rows * cols;
      end else begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 10);
        count = rows * cols * $urandom_range(1, 2);
      end
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      set_frame(rows, cols);
      send_random(count);
      sent += count;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset state of the block
    frame_rows = NUM_ROWS_W'(1);
    frame_cols = NUM_COLS_W'(1);
    row_pos    = 0;
    col_pos    = 0;
    left1      = '0;
    left2      = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      line_up[i]  = '0;
      line_up2[i] = '0;
    end

    rst                 <= 1'b1;
    pix_bus.valid       <= 1'b0;
    pix_bus.pixel_value <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_frame();
    test_extreme_values();
    test_single_line();
    test_register_limits();
    test_restart_and_unknown();
    test_backpressure();
    test_tall_frame();
    test_random_frames();

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/glmf_pkg.sv
rtl/glmf_channels.sv
rtl/glmf_cfg.sv
rtl/glmf_line_mem.sv
rtl/glmf_decide.sv
rtl/glmf_out.sv
rtl/grid_local_maximum_finder_top.sv
tb/sv/tb_top.sv
